### hw/rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants
// Frame layout, register indexes and data type decoding for the framed
// parameter write receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOF_MARKER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_IDS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 3'd4;

	localparam int CFG_DATA_W     = 64;
	localparam int SLOT_COUNT_MAX = 8;
	localparam int DATA_LEN       = 8;

	// Byte positions within a frame
	localparam logic [3:0] POS_HUNT  = 4'd0;
	localparam logic [3:0] POS_TYPE  = 4'd1;
	localparam logic [3:0] POS_ID    = 4'd2;
	localparam logic [3:0] POS_DTYPE = 4'd3;
	localparam logic [3:0] POS_DATA0 = 4'd4;
	localparam logic [3:0] POS_CSUM  = 4'd12;

	// Data type codes
	localparam logic [7:0] DT_U8  = 8'd0;
	localparam logic [7:0] DT_U16 = 8'd1;
	localparam logic [7:0] DT_U32 = 8'd2;
	localparam logic [7:0] DT_F32 = 8'd3;
	localparam logic [7:0] DT_U64 = 8'd4;

	typedef struct packed {
		logic [7:0]  hdr;
		logic [7:0]  ptype;
		logic [7:0]  id;
		logic [7:0]  dtype;
		logic [63:0] data;
	} frame_t;

	typedef struct packed {
		logic done;   // checksum byte taken in this transaction
		logic ok;     // header and checksum match
	} frm_status_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  slot;
		logic [63:0] value;
		logic [3:0]  bytes;
	} wr_t;

	function automatic logic [3:0] size_of_code(input logic [7:0] code);
		logic [3:0] sz;
		case (code)
			DT_U8:   sz = 4'd1;
			DT_U16:  sz = 4'd2;
			DT_U32:  sz = 4'd4;
			DT_F32:  sz = 4'd4;
			DT_U64:  sz = 4'd8;
			default: sz = 4'd0;
		endcase
		return sz;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/frp_if.sv
// ----------------------------------------------------------------------------
// frp_if: channel interfaces
// Valid/ready channels for received items and for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, kind, rx_byte, input ready);
	modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface frp_result_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [2:0]  write_slot;
	logic [63:0] write_value;
	logic [3:0]  write_bytes;
	logic        frame_good;
	logic        frame_bad;
	logic        link_alive;

	modport source (output valid, write_valid, write_slot, write_value, write_bytes,
		frame_good, frame_bad, link_alive, input ready);
	modport sink   (input valid, write_valid, write_slot, write_value, write_bytes,
		frame_good, frame_bad, link_alive, output ready);
endinterface

`default_nettype wire

### hw/rtl/frp_framer.sv
// ----------------------------------------------------------------------------
// frp_framer: frame assembly
// Hunts for the start byte, stores the frame fields and keeps a running XOR.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_framer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_en,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [7:0]          sof_marker,
	output frp_pkg::frame_t          frame,
	output frp_pkg::frm_status_t     status
);
	import frp_pkg::*;

	logic [3:0]  pos_q;
	logic [7:0]  hdr_q;
	logic [7:0]  ptype_q;
	logic [7:0]  id_q;
	logic [7:0]  dtype_q;
	logic [63:0] data_q;
	logic [7:0]  xor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (byte_en) begin
			if (pos_q == POS_HUNT) begin
				if (rx_byte == sof_marker) pos_q <= POS_TYPE;
			end else if (pos_q == POS_CSUM) begin
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			if (pos_q == POS_HUNT) begin
				hdr_q <= rx_byte;
				xor_q <= '0;
			end else if (pos_q != POS_CSUM) begin
				xor_q <= xor_q ^ rx_byte;
			end
			if (pos_q == POS_TYPE)  ptype_q <= rx_byte;
			if (pos_q == POS_ID)    id_q    <= rx_byte;
			if (pos_q == POS_DTYPE) dtype_q <= rx_byte;
			for (int k = 0; k < DATA_LEN; k++) begin
				if (pos_q == POS_DATA0 + 4'(k)) data_q[8*k +: 8] <= rx_byte;
			end
		end
	end

	assign frame.hdr   = hdr_q;
	assign frame.ptype = ptype_q;
	assign frame.id    = id_q;
	assign frame.dtype = dtype_q;
	assign frame.data  = data_q;

	// Header is checked against the current marker, not the one seen at hunt time
	assign status.done = byte_en && (pos_q == POS_CSUM);
	assign status.ok   = (hdr_q == sof_marker) && (xor_q == rx_byte);

endmodule

`default_nettype wire

### hw/rtl/frp_decode.sv
// ----------------------------------------------------------------------------
// frp_decode: write decode
// Matches the frame id against the registered slots and extracts the value.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_decode (
	input  wire frp_pkg::frame_t     frame,
	input  wire logic                good,
	input  wire logic [7:0]          write_code,
	input  wire logic [63:0]         slot_ids,
	input  wire logic [3:0]          slot_count,
	output frp_pkg::wr_t             wr
);
	import frp_pkg::*;

	logic [3:0]              n;
	logic [SLOT_COUNT_MAX-1:0] hit;
	logic                    found;
	logic [2:0]              slot;
	logic [3:0]              sz;
	logic [63:0]             value;

	always_comb begin
		n = (slot_count > 4'(SLOT_COUNT_MAX)) ? 4'(SLOT_COUNT_MAX) : slot_count;
		for (int k = 0; k < SLOT_COUNT_MAX; k++) begin
			hit[k] = (4'(k) < n) && (slot_ids[8*k +: 8] == frame.id);
		end
		// first matching slot wins
		found = 1'b0;
		slot  = '0;
		for (int k = SLOT_COUNT_MAX - 1; k >= 0; k--) begin
			if (hit[k]) begin
				found = 1'b1;
				slot  = 3'(k);
			end
		end
		sz = size_of_code(frame.dtype);
		for (int k = 0; k < DATA_LEN; k++) begin
			value[8*k +: 8] = (4'(k) < sz) ? frame.data[8*k +: 8] : 8'd0;
		end
		wr = '0;
		if (good && (frame.ptype == write_code) && found && (sz != 4'd0)) begin
			wr.valid = 1'b1;
			wr.slot  = slot;
			wr.value = value;
			wr.bytes = sz;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/framed_param_write_receiver.sv
// ----------------------------------------------------------------------------
// framed_param_write_receiver: framed parameter write receiver
// Collects 13-byte XOR-checked frames from a byte stream, decodes slot writes
// and tracks link liveness from millisecond ticks.
// ----------------------------------------------------------------------------
//  channel   dir   transaction
//  item      in    kind (byte or ms tick), rx_byte
//  result    out   write_valid/slot/value/bytes, frame_good, frame_bad, link_alive
//  cfg       in    cfg_we, cfg_index, cfg_wdata (write only)
//
//  One item per cycle unless stalled; its result appears in the cycle after it.
//  The result register holds while result.ready is low; item.ready drops only
//  when that register is full and not being taken.
//  Reset returns to start-byte hunting, clears the ms counter and loads the
//  register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_param_write_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [frp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	frp_item_if.sink                           item,
	frp_result_if.source                       result
);
	import frp_pkg::*;

	logic [7:0]  sof_marker_q;
	logic [7:0]  write_code_q;
	logic [15:0] timeout_ms_q;
	logic [63:0] slot_ids_q;
	logic [3:0]  slot_count_q;

	logic [15:0] elapsed_q;
	logic [15:0] elapsed_next;

	logic        accept;
	logic        byte_en;
	logic        tick;
	logic        good;
	logic        bad;
	frame_t      frame;
	frm_status_t status;
	wr_t         wr;

	logic        res_valid_q;
	wr_t         wr_q;
	logic        good_q;
	logic        bad_q;
	logic        alive_q;

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign byte_en    = accept && !item.kind;
	assign tick       = accept && item.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_marker_q <= 8'd170;
			write_code_q <= 8'd1;
			timeout_ms_q <= 16'd1000;
			slot_ids_q   <= '0;
			slot_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOF_MARKER: sof_marker_q <= cfg_wdata[7:0];
				CFG_WRITE_CODE: write_code_q <= cfg_wdata[7:0];
				CFG_TIMEOUT_MS: timeout_ms_q <= cfg_wdata[15:0];
				CFG_SLOT_IDS:   slot_ids_q   <= cfg_wdata;
				CFG_SLOT_COUNT: slot_count_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	frp_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (byte_en),
		.rx_byte    (item.rx_byte),
		.sof_marker (sof_marker_q),
		.frame      (frame),
		.status     (status)
	);

	assign good = status.done && status.ok;
	assign bad  = status.done && !status.ok;

	frp_decode u_decode (
		.frame      (frame),
		.good       (good),
		.write_code (write_code_q),
		.slot_ids   (slot_ids_q),
		.slot_count (slot_count_q),
		.wr         (wr)
	);

	// saturate on tick, clear on good frame
	always_comb begin
		elapsed_next = elapsed_q;
		if (tick) begin
			if (elapsed_q != 16'hFFFF) elapsed_next = elapsed_q + 16'd1;
		end else if (good) begin
			elapsed_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) elapsed_q <= elapsed_next;
			if (accept)            res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_q    <= wr;
			good_q  <= good;
			bad_q   <= bad;
			alive_q <= elapsed_next < timeout_ms_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.write_valid = wr_q.valid;
	assign result.write_slot  = wr_q.slot;
	assign result.write_value = wr_q.value;
	assign result.write_bytes = wr_q.bytes;
	assign result.frame_good  = good_q;
	assign result.frame_bad   = bad_q;
	assign result.link_alive  = alive_q;

endmodule

`default_nettype wire

### hw/rtl/frp_checker.sv
// ----------------------------------------------------------------------------
// frp_checker: port-level checks
// Consistency of the result fields as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_valid,
	input  wire logic        res_ready,
	input  wire logic        write_valid,
	input  wire logic [2:0]  write_slot,
	input  wire logic [63:0] write_value,
	input  wire logic [3:0]  write_bytes,
	input  wire logic        frame_good,
	input  wire logic        frame_bad
);

	a_good_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(frame_good && frame_bad))
		else $error("frame_good and frame_bad both set");

	a_write_needs_good: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && write_valid) |-> frame_good)
		else $error("write reported without a good frame");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !write_valid) |->
			(write_slot == 3'd0 && write_value == 64'd0 && write_bytes == 4'd0))
		else $error("write fields nonzero without a write");

	a_write_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && write_valid) |->
			(write_bytes == 4'd1 || write_bytes == 4'd2 ||
			 write_bytes == 4'd4 || write_bytes == 4'd8))
		else $error("illegal write length");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(write_value)))
		else $error("stalled result changed");

endmodule

bind framed_param_write_receiver frp_checker u_frp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.write_valid (result.write_valid),
	.write_slot  (result.write_slot),
	.write_value (result.write_value),
	.write_bytes (result.write_bytes),
	.frame_good  (result.frame_good),
	.frame_bad   (result.frame_bad)
);

`default_nettype wire
